/* sv/jptrl_pkg.sv */
`default_nettype none
package jptrl_pkg;

    // Joint count and index width
    localparam int NUM_JOINTS_DEF = 7;
    localparam int JOINT_W        = 3;
    localparam int JOINT_TAB_N    = 2 ** JOINT_W;

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 24;
    localparam int RATE_W     = 31;
    localparam int GAIN_W     = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    // Shared multiplier and accumulator widths
    localparam int MUL_A_W = DATA_W + 1;
    localparam int MUL_B_W = STEP_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 48;

    // Per-joint memory word: previous torque over error integral
    localparam int STATE_W = 2 * DATA_W;

    // Stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 1'd1;

    // Reset values of the configuration registers
    localparam logic [RATE_W-1:0] RATE_LIMIT_RST  = 31'd1310720;
    localparam logic [STEP_W-1:0] STEP_LENGTH_RST = 24'd16777;

    // Gain tables, one entry per joint index; the eighth joint has no gains
    localparam logic [GAIN_W-1:0] KP_TABLE [JOINT_TAB_N] =
        '{10'd500, 10'd500, 10'd500, 10'd500, 10'd200, 10'd100, 10'd50, 10'd0};
    localparam logic [GAIN_W-1:0] KD_TABLE [JOINT_TAB_N] =
        '{10'd64, 10'd80, 10'd60, 10'd90, 10'd40, 10'd40, 10'd20, 10'd0};
    localparam logic [GAIN_W-1:0] KI_TABLE [JOINT_TAB_N] =
        '{10'd30, 10'd30, 10'd40, 10'd80, 10'd80, 10'd60, 10'd80, 10'd0};

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_KP,
        ST_KD,
        ST_KI,
        ST_SUM,
        ST_SAT,
        ST_OUT
    } t_state;

    // Accumulator operations
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB,
        ACC_ADD
    } t_acc_op;

    // Control bundle for the multiply-accumulate unit
    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctl;

    // Saturation result
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic t_sat sat32(input logic signed [ACC_W-1:0] x);
        t_sat r;
        r.hit = 1'b0;
        r.val = x[DATA_W-1:0];
        if (x > ACC_W'(64'sh7FFF_FFFF)) begin
            r.hit = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end else if (x < -(ACC_W'(64'sh8000_0000))) begin
            r.hit = 1'b1;
            r.val = 32'sh8000_0000;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/jptrl_ram.sv */
`default_nettype none
module jptrl_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 7,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* sv/jptrl_mac.sv */
`default_nettype none
module jptrl_mac (
    input  wire logic                               i_clk,
    input  wire jptrl_pkg::t_mac_ctl                i_ctl,
    input  wire logic signed [jptrl_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [jptrl_pkg::MUL_B_W-1:0] i_b,
    output logic signed      [jptrl_pkg::PROD_W-1:0]  o_prod,
    output logic signed      [jptrl_pkg::ACC_W-1:0]   o_acc
);
    import jptrl_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_w;

    // Products fed to the accumulator always fit its width
    assign prod_w = ACC_W'(r_prod);
    assign n_prod = i_a * i_b;

    // Accumulate the registered product
    always_comb begin
        unique case (i_ctl.acc_op)
            ACC_HOLD: n_acc = r_acc;
            ACC_LOAD: n_acc = prod_w;
            ACC_SUB:  n_acc = r_acc - prod_w;
            ACC_ADD:  n_acc = r_acc + prod_w;
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= n_prod;
        end
        r_acc <= n_acc;
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

/* sv/joint_pid_torque_rate_limit.sv */
`default_nettype none
// Per-joint PID torque controller with a rate limit on the output. Each input
// beat is one joint sample; each produces exactly one output beat carrying the
// joint index, the new torque command and two flags. Per-joint error integral
// and previous torque live in one small synchronous RAM, read when a sample is
// taken and written back when its result goes out; valid bits make never
// written joints read as zero after reset, so no clearing pass is needed.
// One shared multiplier works through error*step, Kp*error, Kd*velocity and
// Ki*integral in turn; a sample steps through STEP, KP, KD, KI, SUM, SAT and
// OUT before its result enters the output register, and no new sample is taken
// until then. A full output register that is not drained holds the sample at
// its last step and delays the next input beat by the stall. A sample whose
// joint index is not below NUM_JOINTS skips the arithmetic, goes straight to
// OUT, returns a zero torque with both flags clear and touches no state. Gains
// are fixed per joint. Write rate_limit and step_length only while no sample
// is in flight.
module joint_pid_torque_rate_limit #(
    parameter int NUM_JOINTS = jptrl_pkg::NUM_JOINTS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [jptrl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [jptrl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Sample input
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [2:0] joint_index, [34:3] target_position, [66:35] measured_position,
    // [98:67] measured_velocity, [103:99] zero
    input  wire logic [jptrl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // Torque output
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [2:0] joint_out, [34:3] torque_command, [39:35] zero
    output logic      [jptrl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] rate_limited, [1] saturated
    output logic      [jptrl_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    import jptrl_pkg::*;

    localparam int ADDR_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // Sequencer
    t_state r_state;
    t_state n_state;

    // Configuration registers
    logic [RATE_W-1:0] r_rate_limit;
    logic [STEP_W-1:0] r_step_len;

    // Sample registers
    logic [JOINT_W-1:0]        r_joint;
    logic                      r_skip;
    logic signed [MUL_A_W-1:0] r_err;
    logic signed [DATA_W-1:0]  r_vel;
    logic                      r_rd_vld;
    logic signed [DATA_W-1:0]  r_integ;
    logic                      r_sat;
    logic signed [DATA_W-1:0]  r_pid;

    // Per-joint valid bits for the state RAM
    logic [NUM_JOINTS-1:0] r_vld;

    // Output register
    logic                     r_out_vld;
    logic [JOINT_W-1:0]       r_out_joint;
    logic signed [DATA_W-1:0] r_out_torque;
    logic                     r_out_lim;
    logic                     r_out_sat;

    // Control
    logic     accept;
    logic     out_free;
    logic     ld_integ;
    logic     ld_pid;
    logic     ld_out;
    logic     ram_we;
    t_mac_ctl mac_ctl;

    // Datapath
    logic [JOINT_W-1:0]        in_joint;
    logic                      in_range;
    logic [ADDR_W-1:0]         in_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0]  in_target;
    logic signed [DATA_W-1:0]  in_meas;
    logic signed [DATA_W-1:0]  in_vel;
    logic [STATE_W-1:0]        ram_rdata;
    logic [STATE_W-1:0]        ram_wdata;
    logic signed [DATA_W-1:0]  old_integ;
    logic signed [DATA_W-1:0]  prev_torque;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mac_prod;
    logic signed [ACC_W-1:0]   mac_acc;
    logic signed [PROD_W-1:0]  rnd_prod;
    logic signed [ACC_W-1:0]   integ_sum;
    t_sat                      integ_sat;
    t_sat                      pid_sat;
    logic signed [DATA_W:0]    delta;
    logic signed [DATA_W:0]    lim_pos;
    logic signed [DATA_W:0]    lim_neg;
    logic signed [DATA_W:0]    delta_cl;
    logic                      limited;
    logic signed [DATA_W-1:0]  torque;

    // Unpack the input beat
    assign in_joint  = s_axis_tdata[2:0];
    assign in_target = s_axis_tdata[34:3];
    assign in_meas   = s_axis_tdata[66:35];
    assign in_vel    = s_axis_tdata[98:67];
    assign in_range  = (32'(in_joint) < 32'(NUM_JOINTS));
    assign in_addr   = ADDR_W'(in_joint);
    assign wr_addr   = ADDR_W'(r_joint);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    // Never written joints read as zero
    assign old_integ   = r_rd_vld ? signed'(ram_rdata[DATA_W-1:0]) : '0;
    assign prev_torque = r_rd_vld ? signed'(ram_rdata[STATE_W-1:DATA_W]) : '0;

    // Round error*step to Q16.16 and saturate the new integral
    assign rnd_prod  = mac_prod + PROD_W'(64'sh80_0000);
    assign integ_sum = ACC_W'(old_integ) + ACC_W'(signed'(rnd_prod[PROD_W-1:STEP_W]));
    assign integ_sat = sat32(integ_sum);

    // Saturate the PID sum
    assign pid_sat = sat32(mac_acc);

    // Clamp the change against the previous torque
    assign delta   = (DATA_W+1)'(r_pid) - (DATA_W+1)'(prev_torque);
    assign lim_pos = signed'({2'b00, r_rate_limit});
    assign lim_neg = -lim_pos;
    always_comb begin
        limited  = 1'b0;
        delta_cl = delta;
        if (delta > lim_pos) begin
            limited  = 1'b1;
            delta_cl = lim_pos;
        end else if (delta < lim_neg) begin
            limited  = 1'b1;
            delta_cl = lim_neg;
        end
    end
    assign torque    = DATA_W'((DATA_W+1)'(prev_torque) + delta_cl);
    assign ram_wdata = {torque, r_integ};

    // Next state, multiplier operands and load strobes
    always_comb begin
        n_state        = r_state;
        mac_ctl.mul_en = 1'b0;
        mac_ctl.acc_op = ACC_HOLD;
        mul_a          = r_err;
        mul_b          = signed'(MUL_B_W'(r_step_len));
        ld_integ       = 1'b0;
        ld_pid         = 1'b0;
        ld_out         = 1'b0;
        ram_we         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = in_range ? ST_STEP : ST_OUT;
                end
            end
            ST_STEP: begin
                mac_ctl.mul_en = 1'b1;
                n_state        = ST_KP;
            end
            ST_KP: begin
                ld_integ       = 1'b1;
                mac_ctl.mul_en = 1'b1;
                mul_b          = signed'(MUL_B_W'(KP_TABLE[r_joint]));
                n_state        = ST_KD;
            end
            ST_KD: begin
                mac_ctl.acc_op = ACC_LOAD;
                mac_ctl.mul_en = 1'b1;
                mul_a          = MUL_A_W'(r_vel);
                mul_b          = signed'(MUL_B_W'(KD_TABLE[r_joint]));
                n_state        = ST_KI;
            end
            ST_KI: begin
                mac_ctl.acc_op = ACC_SUB;
                mac_ctl.mul_en = 1'b1;
                mul_a          = MUL_A_W'(r_integ);
                mul_b          = signed'(MUL_B_W'(KI_TABLE[r_joint]));
                n_state        = ST_SUM;
            end
            ST_SUM: begin
                mac_ctl.acc_op = ACC_ADD;
                n_state        = ST_SAT;
            end
            ST_SAT: begin
                ld_pid  = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    ram_we  = !r_skip;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state: sequencer, configuration, valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rate_limit <= RATE_LIMIT_RST;
            r_step_len   <= STEP_LENGTH_RST;
            r_vld        <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE_LIMIT:  r_rate_limit <= i_cfg_data[RATE_W-1:0];
                    CFG_STEP_LENGTH: r_step_len   <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (ram_we) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (ld_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_joint  <= in_joint;
            r_skip   <= !in_range;
            r_err    <= MUL_A_W'(in_target) - MUL_A_W'(in_meas);
            r_vel    <= in_vel;
            r_rd_vld <= in_range && r_vld[in_addr];
        end
        if (ld_integ) begin
            r_integ <= integ_sat.val;
            r_sat   <= integ_sat.hit;
        end
        if (ld_pid) begin
            r_pid <= pid_sat.val;
            r_sat <= r_sat || pid_sat.hit;
        end
        if (ld_out) begin
            r_out_joint  <= r_joint;
            r_out_torque <= r_skip ? '0 : torque;
            r_out_lim    <= !r_skip && limited;
            r_out_sat    <= !r_skip && r_sat;
        end
    end

    // Per-joint integral and previous torque
    jptrl_ram #(
        .DATA_W (STATE_W),
        .DEPTH  (NUM_JOINTS),
        .ADDR_W (ADDR_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // Shared multiplier and accumulator
    jptrl_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    // Pack the output beat
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b00000, r_out_torque, r_out_joint};
    assign m_axis_tuser  = {r_out_sat, r_out_lim};

endmodule
`default_nettype wire
